@@ rtl/kwsm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwsm_pkg
// Shared codes and control types for the sorted merge block and its cells.
// ----------------------------------------------------------------------------
package kwsm_pkg;

    localparam logic       OP_PUSH  = 1'b0;
    localparam logic       OP_PULL  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DROP  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic push;
        logic take;
        logic clear;
    } cell_cmd_t;

    typedef struct packed {
        logic full;
        logic nonempty;
        logic remain;
    } cell_flags_t;

endpackage
`default_nettype wire

@@ rtl/kwsm_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwsm_cell
// One list of the merge: its element memory, read position and fill count,
// and one link of the minimum-scan chain.
// ----------------------------------------------------------------------------
module kwsm_cell #(
    parameter int CELL_IDX    = 0,
    parameter int IDX_W       = 3,
    parameter int LIST_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire kwsm_pkg::cell_cmd_t    cmd,
    input  wire logic [2:0]             push_idx,
    input  wire logic [VALUE_WIDTH-1:0] push_word,
    input  wire logic [IDX_W-1:0]       sel_idx,
    input  wire logic                   best_in_valid,
    input  wire logic [VALUE_WIDTH-1:0] best_in_value,
    input  wire logic [IDX_W-1:0]       best_in_idx,
    output logic                        best_out_valid,
    output logic [VALUE_WIDTH-1:0]      best_out_value,
    output logic [IDX_W-1:0]            best_out_idx,
    output kwsm_pkg::cell_flags_t       flags
);
    import kwsm_pkg::*;

    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic [VALUE_WIDTH-1:0] mem [LIST_DEPTH];
    logic [VALUE_WIDTH-1:0] head_reg;
    logic [CNT_W-1:0]       rp_reg;
    logic [CNT_W-1:0]       fill_reg;
    logic                   best_valid_reg;
    logic [VALUE_WIDTH-1:0] best_value_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic                   nonempty;
    logic                   full;
    logic                   selected;
    logic                   wr_en;
    logic                   win;

    assign nonempty = rp_reg < fill_reg;
    assign full     = fill_reg >= CNT_W'(LIST_DEPTH);
    assign selected = sel_idx == IDX_W'(CELL_IDX);
    assign wr_en    = cmd.push && (32'(push_idx) == CELL_IDX) && !full;
    assign win      = nonempty &&
                      (!best_in_valid || ($signed(head_reg) <= $signed(best_in_value)));

    assign flags.full     = full;
    assign flags.nonempty = nonempty;
    assign flags.remain   = selected ? (CNT_W'(rp_reg + 1'b1) < fill_reg) : nonempty;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_reg[ADDR_W-1:0]] <= push_word;
        end
        head_reg <= mem[rp_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg         <= '0;
            fill_reg       <= '0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            best_valid_reg <= win || best_in_valid;
            if (cmd.clear)
            begin
                rp_reg   <= '0;
                fill_reg <= '0;
            end
            else
            begin
                if (cmd.take && selected)
                begin
                    rp_reg <= CNT_W'(rp_reg + 1'b1);
                end
                if (wr_en)
                begin
                    fill_reg <= CNT_W'(fill_reg + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (win)
        begin
            best_value_reg <= head_reg;
            best_idx_reg   <= IDX_W'(CELL_IDX);
        end
        else
        begin
            best_value_reg <= best_in_value;
            best_idx_reg   <= best_in_idx;
        end
    end

    assign best_out_valid = best_valid_reg;
    assign best_out_value = best_value_reg;
    assign best_out_idx   = best_idx_reg;

endmodule
`default_nettype wire

@@ rtl/k_way_sorted_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Push: after acceptance, result registered in S_PUSH once the result slot is free.
// Pull: result registered in S_TAKE, after S_SCAN, once the result slot is free;
//   the scan moves the running minimum one list cell per cycle down the chain.
// One request in flight at a time; a new request is accepted only in S_IDLE.
// Reset clears read positions and fill counts; the element memories are not cleared.
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Merge of up to NUM_LISTS sorted lists held in a chain of list cells.
// ----------------------------------------------------------------------------
module k_way_sorted_merge #(
    parameter int NUM_LISTS   = 8,
    parameter int LIST_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               opcode,
    input  wire logic [2:0]         list_index,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              status,
    output logic signed [31:0]      merged_value,
    output logic                    last
);
    import kwsm_pkg::*;

    localparam int IDX_W = $clog2(NUM_LISTS);
    localparam int SCN_W = $clog2(NUM_LISTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_TAKE
    } state_t;

    state_t                 state_reg;
    logic [SCN_W-1:0]       scan_cnt_reg;
    logic [2:0]             idx_reg;
    logic [VALUE_WIDTH-1:0] word_reg;
    logic                   out_valid_reg;
    logic [1:0]             status_reg;
    logic [31:0]            merged_reg;
    logic                   last_reg;

    cell_cmd_t              cmd;
    cell_flags_t            flags [NUM_LISTS];
    logic                   chain_valid [NUM_LISTS+1];
    logic [VALUE_WIDTH-1:0] chain_value [NUM_LISTS+1];
    logic [IDX_W-1:0]       chain_idx   [NUM_LISTS+1];

    logic                   slot_free;
    logic                   load_result;
    logic                   push_full;
    logic                   any_left;
    logic                   any_nonempty;
    logic                   accept;

    assign in_ready    = state_reg == S_IDLE;
    assign accept      = in_valid && in_ready;
    assign slot_free   = !out_valid_reg || out_ready;
    assign load_result = ((state_reg == S_PUSH) || (state_reg == S_TAKE)) && slot_free;

    always_comb
    begin
        push_full    = 1'b1;
        any_left     = 1'b0;
        any_nonempty = 1'b0;
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            if (32'(idx_reg) == i)
            begin
                push_full = flags[i].full;
            end
            any_left     = any_left || flags[i].remain;
            any_nonempty = any_nonempty || flags[i].nonempty;
        end
    end

    assign cmd.push  = (state_reg == S_PUSH) && slot_free;
    assign cmd.take  = (state_reg == S_TAKE) && slot_free && chain_valid[NUM_LISTS];
    assign cmd.clear = cmd.take && !any_left;

    assign chain_valid[0] = 1'b0;
    assign chain_value[0] = '0;
    assign chain_idx[0]   = '0;

    for (genvar g = 0; g < NUM_LISTS; g++)
    begin : g_cell
        kwsm_cell #(
            .CELL_IDX    (g),
            .IDX_W       (IDX_W),
            .LIST_DEPTH  (LIST_DEPTH),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .cmd            (cmd),
            .push_idx       (idx_reg),
            .push_word      (word_reg),
            .sel_idx        (chain_idx[NUM_LISTS]),
            .best_in_valid  (chain_valid[g]),
            .best_in_value  (chain_value[g]),
            .best_in_idx    (chain_idx[g]),
            .best_out_valid (chain_valid[g+1]),
            .best_out_value (chain_value[g+1]),
            .best_out_idx   (chain_idx[g+1]),
            .flags          (flags[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !load_result)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    scan_cnt_reg <= '0;
                    if (accept)
                    begin
                        state_reg <= (opcode == OP_PULL) ? S_SCAN : S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_SCAN:
                begin
                    scan_cnt_reg <= SCN_W'(scan_cnt_reg + 1'b1);
                    if (scan_cnt_reg == SCN_W'(NUM_LISTS))
                    begin
                        state_reg <= S_TAKE;
                    end
                end
                S_TAKE:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg  <= list_index;
            word_reg <= VALUE_WIDTH'(value);
        end
        if (cmd.push)
        begin
            status_reg <= push_full ? ST_DROP : ST_OK;
            merged_reg <= '0;
            last_reg   <= 1'b0;
        end
        else if ((state_reg == S_TAKE) && slot_free)
        begin
            if (chain_valid[NUM_LISTS])
            begin
                status_reg <= ST_OK;
                merged_reg <= 32'($signed(chain_value[NUM_LISTS]));
                last_reg   <= !any_left;
            end
            else
            begin
                status_reg <= ST_EMPTY;
                merged_reg <= '0;
                last_reg   <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign merged_value = merged_reg;
    assign last         = last_reg;

    a_last_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (status == ST_OK))
        else $error("last marked on a result that is not ok");

    a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> ((merged_value == 32'd0) && !last))
        else $error("failed request carries a value or last");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> !any_nonempty)
        else $error("lists not empty after the final pull");

    a_take_from_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> any_nonempty)
        else $error("pull consumed from empty lists");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge testbench
// Sends push and pull requests through the valid/ready request channel with
// random request gaps and result stalls. A behavioral copy of the list store
// predicts status, merged value and last flag for every accepted request. A
// checker compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    import kwsm_pkg::*;

    localparam int N_LISTS    = 8;
    localparam int DEPTH      = 64;
    localparam int CYCLE_CAP  = 400000;
    localparam int RANDOM_END = 650;
    localparam int QUIET_END  = 800;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic               last;
    } merge_result_t;

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic               opcode     = OP_PUSH;
    logic [2:0]         list_index = 3'd0;
    logic signed [31:0] value      = 32'sd0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] merged_value;
    logic               last;

    logic signed [31:0] list_mem [N_LISTS][DEPTH];
    logic [6:0]         list_rd [N_LISTS];
    logic [6:0]         list_fill [N_LISTS];

    merge_result_t merged_results_q [$];
    int            errors        = 0;
    int            requests_sent = 0;
    int            cycles        = 0;
    bit            idle_on       = 1'b0;
    bit            stall_on      = 1'b0;

    k_way_sorted_merge i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .list_index   (list_index),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .merged_value (merged_value),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic merge_result_t predict_merge(logic op, logic [2:0] idx,
                                                    logic signed [31:0] val);
        merge_result_t r;
        int            best;
        int            i;
        bit            any_left;
        r.status = ST_OK;
        r.value  = 32'sd0;
        r.last   = 1'b0;
        best     = -1;
        any_left = 1'b0;
        if (op == OP_PUSH)
        begin
            if (idx >= N_LISTS || list_fill[idx] >= DEPTH)
            begin
                r.status = ST_DROP;
            end
            else
            begin
                list_mem[idx][list_fill[idx]] = val;
                list_fill[idx] = list_fill[idx] + 7'd1;
            end
        end
        else
        begin
            for (i = 0; i < N_LISTS; i++)
            begin
                if (list_rd[i] < list_fill[i])
                begin
                    if (best < 0 || list_mem[i][list_rd[i]] <= list_mem[best][list_rd[best]])
                        best = i;
                end
            end
            if (best < 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.value = list_mem[best][list_rd[best]];
                list_rd[best] = list_rd[best] + 7'd1;
                for (i = 0; i < N_LISTS; i++)
                    if (list_rd[i] < list_fill[i])
                        any_left = 1'b1;
                if (!any_left)
                begin
                    r.last = 1'b1;
                    for (i = 0; i < N_LISTS; i++)
                    begin
                        list_rd[i]   = 7'd0;
                        list_fill[i] = 7'd0;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic int stored_count();
        int n;
        int i;
        n = 0;
        for (i = 0; i < N_LISTS; i++)
            n += list_fill[i] - list_rd[i];
        return n;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 6))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2, 3: return $signed($urandom_range(0, 15)) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(logic op, logic [2:0] idx, logic signed [31:0] val);
        in_valid   <= 1'b1;
        opcode     <= op;
        list_index <= idx;
        value      <= val;
        do @(posedge clk); while (!in_ready);
        merged_results_q.insert(merged_results_q.size(), predict_merge(op, idx, val));
        requests_sent++;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (merged_results_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic drain_lists();
        while (stored_count() != 0)
            send_request(OP_PULL, 3'($urandom_range(0, 7)), $urandom);
    endtask

    task automatic test_empty_pull();
        send_request(OP_PULL, 3'd0, 32'sd0);
        send_request(OP_PULL, 3'd7, 32'shffff_ffff);
    endtask

    task automatic test_extremes();
        send_request(OP_PUSH, 3'd0, 32'sh7fff_ffff);
        send_request(OP_PUSH, 3'd7, 32'sh8000_0000);
        send_request(OP_PUSH, 3'd3, 32'sd0);
        send_request(OP_PUSH, 3'd4, 32'shffff_ffff);
        send_request(OP_PUSH, 3'd7, 32'sh7fff_ffff);
        drain_lists();
        send_request(OP_PULL, 3'd5, 32'sh5555_aaaa);
    endtask

    task automatic test_equal_heads();
        send_request(OP_PUSH, 3'd2, 32'sd5);
        send_request(OP_PUSH, 3'd2, 32'sd100);
        send_request(OP_PUSH, 3'd6, 32'sd5);
        send_request(OP_PUSH, 3'd6, 32'sd1);
        send_request(OP_PUSH, 3'd1, 32'sd5);
        drain_lists();
    endtask

    task automatic test_append_after_pull();
        send_request(OP_PUSH, 3'd1, 32'sd10);
        send_request(OP_PUSH, 3'd1, 32'sd20);
        send_request(OP_PULL, 3'd0, 32'sd0);
        send_request(OP_PUSH, 3'd1, -32'sd5);
        drain_lists();
    endtask

    task automatic test_full_list();
        logic signed [31:0] v;
        int                 i;
        v = -32'sd40;
        for (i = 0; i < DEPTH; i++)
        begin
            v = v + $urandom_range(0, 2);
            send_request(OP_PUSH, 3'd5, v);
        end
        send_request(OP_PUSH, 3'd5, 32'sd1);
        send_request(OP_PUSH, 3'd2, 32'sd0);
        repeat (3) send_request(OP_PULL, 3'd0, 32'sd0);
        send_request(OP_PUSH, 3'd5, 32'sd7);
        drain_lists();
        send_request(OP_PUSH, 3'd5, 32'sd9);
        send_request(OP_PULL, 3'd0, 32'sd0);
    endtask

    task automatic run_merge_round();
        logic signed [31:0] tail [N_LISTS];
        logic [2:0]         idx;
        int                 n_push;
        int                 span;
        bit                 sorted_lists;
        int                 i;
        n_push       = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 130)
                                                   : $urandom_range(1, 24);
        span         = $urandom_range(0, 7);
        sorted_lists = $urandom_range(0, 3) != 0;
        for (i = 0; i < N_LISTS; i++)
            tail[i] = pick_value();
        repeat (n_push)
        begin
            idx = (span == 7) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, span));
            if ($urandom_range(0, 9) == 0)
            begin
                send_request(OP_PULL, idx, $urandom);
            end
            else
            begin
                if (sorted_lists)
                    tail[idx] = tail[idx] + $urandom_range(0, 3);
                else
                    tail[idx] = pick_value();
                send_request(OP_PUSH, idx, tail[idx]);
            end
        end
        drain_lists();
        if ($urandom_range(0, 1) == 0)
            send_request(OP_PULL, 3'($urandom_range(0, 7)), $urandom);
    endtask

    task automatic run_noise_round();
        repeat ($urandom_range(4, 30))
            send_request(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), pick_value());
    endtask

    task automatic test_random_traffic(int stop_at, bit quiet);
        while (requests_sent < stop_at)
        begin
            idle_on  = !quiet && $urandom_range(0, 3) != 0;
            stall_on = !quiet && $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 3) == 0)
                run_noise_round();
            else
                run_merge_round();
            if (!quiet && $urandom_range(0, 7) == 0)
                wait_results_drained();
        end
    endtask

    always
    begin
        @(posedge clk);
        if (stall_on && $urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        merge_result_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            if (merged_results_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d value %0d",
                         $time, status, merged_value);
                errors++;
            end
            else
            begin
                exp = merged_results_q.pop_front();
                if (status !== exp.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, exp.status, status);
                    errors++;
                end
                if (merged_value !== exp.value)
                begin
                    $display("%0t: merged_value expected %0d actual %0d",
                             $time, exp.value, merged_value);
                    errors++;
                end
                if (last !== exp.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time, exp.last, last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("k_way_sorted_merge: mismatch");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < N_LISTS; i++)
        begin
            list_rd[i]   = 7'd0;
            list_fill[i] = 7'd0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        stall_on = 1'b1;
        idle_on  = 1'b1;
        test_empty_pull();
        test_extremes();
        test_equal_heads();
        test_append_after_pull();
        wait_results_drained();
        test_full_list();
        test_random_traffic(RANDOM_END, 1'b0);
        wait_results_drained();
        test_random_traffic(QUIET_END, 1'b1);
        wait_results_drained();
        repeat (30) @(posedge clk);
        if (errors == 0 && merged_results_q.size() == 0)
            $display("k_way_sorted_merge: match");
        else
            $display("k_way_sorted_merge: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/kwsm_pkg.sv
rtl/kwsm_cell.sv
rtl/k_way_sorted_merge.sv
tb/tb.sv
